### rtl/rrw_pkg.sv
// ----------------------------------------------------------------------------
// rrw_pkg
// Shared types and constants for the reorder window: beat formats, result
// kinds, slot word layout and the sequencer states.
// ----------------------------------------------------------------------------
package rrw_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int WINDOW_DEF   = 32;

    localparam int SEQ_W  = 32;
    localparam int CH_W   = 8;
    localparam int SUB_W  = 8;
    localparam int PAY_W  = 32;
    localparam int SPAN_W = 8;

    typedef enum logic {
        OP_ACCEPT = 1'b0,
        OP_POP    = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        KIND_ADVANCED = 3'd0,
        KIND_GAP      = 3'd1,
        KIND_POPPED   = 3'd2,
        KIND_NONE     = 3'd3,
        KIND_REJECT   = 3'd4
    } kind_t;

    typedef struct packed {
        op_t               operation;
        logic [CH_W-1:0]   channel;
        logic [SEQ_W-1:0]  sequence_req;
        logic [SUB_W-1:0]  subtype;
        logic [PAY_W-1:0]  payload;
    } req_t;

    typedef struct packed {
        kind_t             kind;
        logic [CH_W-1:0]   out_channel;
        logic [SEQ_W-1:0]  first_sequence;
        logic [SEQ_W-1:0]  last_sequence;
        logic [SUB_W-1:0]  out_subtype;
        logic [PAY_W-1:0]  out_payload;
        logic              last;
    } rsp_t;

    // one window slot as kept in the slot memory
    typedef struct packed {
        logic              present;
        logic [SEQ_W-1:0]  seq;
        logic [SUB_W-1:0]  sub;
        logic [PAY_W-1:0]  pay;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'd0,
        ST_IDLE   = 4'd1,
        ST_LOAD   = 4'd2,
        ST_SLOT   = 4'd3,
        ST_WALK   = 4'd4,
        ST_GAPCHK = 4'd5,
        ST_POP    = 4'd6,
        ST_POPRD  = 4'd7,
        ST_REJ    = 4'd8,
        ST_FIN    = 4'd9
    } state_t;

endpackage

### rtl/rrw_ram.sv
// ----------------------------------------------------------------------------
// rrw_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module rrw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/rrw_seqmod.sv
// ----------------------------------------------------------------------------
// rrw_seqmod
// Sequence number modulo window size. Reciprocal multiply, then one
// conditional subtract. The product and the first remainder are registered.
// ----------------------------------------------------------------------------
module rrw_seqmod
    import rrw_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,
    localparam int IW    = $clog2(WINDOW)
) (
    input  logic             clk,
    input  logic             en,
    input  logic [SEQ_W-1:0] x,
    output logic [IW-1:0]    idx
);

    // floor(2^32 / WINDOW): quotient estimate is low by at most one
    localparam logic [SEQ_W-1:0] RECIP = SEQ_W'(64'h1_0000_0000 / 64'(WINDOW));

    logic [2*SEQ_W-1:0] prod_reg;
    logic [SEQ_W-1:0]   x_reg;
    logic [IW:0]        r0_reg;
    logic [SEQ_W-1:0]   qw;
    logic [SEQ_W-1:0]   diff;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= {{SEQ_W{1'b0}}, x} * {{SEQ_W{1'b0}}, RECIP};
            x_reg    <= x;
        end
        r0_reg <= diff[IW:0];
    end

    assign qw   = SEQ_W'(prod_reg[2*SEQ_W-1:SEQ_W] * SEQ_W'(WINDOW));
    assign diff = x_reg - qw;   // below 2*WINDOW

    assign idx = (r0_reg >= (IW+1)'(WINDOW)) ? IW'(r0_reg - (IW+1)'(WINDOW))
                                              : r0_reg[IW-1:0];

endmodule

### rtl/reliable_reorder_window.sv
// ----------------------------------------------------------------------------
// reliable_reorder_window
// Per-channel reorder window: stores packets by sequence, advances the
// in-order point, raises gap requests and hands out in-order packets.
// ----------------------------------------------------------------------------
// Usage
//   req beat (valid/ready): operation 0 stores a packet into its channel's
//   window, operation 1 pops the next in-order packet. One beat is worked on
//   at a time; req_ready is high only while the sequencer is idle.
//   rsp beat (valid/ready): zero or more results per request, the final one
//   flagged with last. Results of one request come out in order.
//   cfg_we/cfg_wdata: writes refill_span; write only while idle.
// Sequence
//   Accept: IDLE, LOAD, SLOT, WALK while slots advance (up to WINDOW), GAPCHK,
//   FIN. Pop: IDLE, LOAD, POP, POPRD, FIN, no POPRD if nothing is ready.
//   Reject: IDLE, REJ, FIN. Slot reads are registered, one read per walked slot.
// Reset
//   After rst_n releases, a clearing pass writes every slot and channel
//   entry to zero, going through each slot address in turn, req_ready low.
// Stall
//   A finished result sits in the output register while the next is staged;
//   if the receiver holds rsp_ready low the sequencer waits, nothing dropped.
// ----------------------------------------------------------------------------
module reliable_reorder_window
    import rrw_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int WINDOW   = WINDOW_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  req_t              req,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rsp_t              rsp,
    input  logic              cfg_we,
    input  logic [SPAN_W-1:0] cfg_wdata
);

    localparam int DEPTH = CHANNELS * WINDOW;
    localparam int SAW   = $clog2(DEPTH);                        // slot address
    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1; // channel address
    localparam int IW    = $clog2(WINDOW);                       // slot in window
    localparam int GW    = IW + 1;                               // walk count
    localparam int PW    = CW + IW + 1;
    // channel word: {gap, rd_idx, rd, exp}
    localparam int CHW   = 1 + IW + 2 * SEQ_W;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    state_t              state_reg, state_next;
    logic [SAW-1:0]      clr_reg, clr_next;
    logic [SPAN_W-1:0]   span_reg;

    // captured request
    op_t                 op_reg, op_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [SEQ_W-1:0]    seq_reg, seq_next;
    logic [SUB_W-1:0]    sub_reg, sub_next;
    logic [PAY_W-1:0]    pay_reg, pay_next;

    // working copy of the channel entry
    logic [SEQ_W-1:0]    exp_reg, exp_next;
    logic [SEQ_W-1:0]    rd_reg, rd_next;
    logic [IW-1:0]       rdidx_reg, rdidx_next;
    logic                gap_reg, gap_next;

    // walk position: slot in window being read, slots advanced so far
    logic [IW-1:0]       cidx_reg, cidx_next;
    logic [GW-1:0]       guard_reg, guard_next;

    // staged result (last not yet known) and output register
    rsp_t                pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    rsp_t                rsp_reg, rsp_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // ------------------------------------------------------------------
    // memories and modulo unit
    // ------------------------------------------------------------------
    logic                slot_we, slot_re;
    logic [SAW-1:0]      slot_waddr, slot_raddr;
    slot_t               slot_wdata;
    logic [SLOT_W-1:0]   slot_rbits;
    slot_t               slot_rd;

    logic                chan_we, chan_re;
    logic [CW-1:0]       chan_waddr, chan_raddr;
    logic [CHW-1:0]      chan_wdata, chan_rdata;

    logic                mod_en;
    logic [IW-1:0]       mod_idx;

    rrw_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rbits)
    );

    assign slot_rd = slot_t'(slot_rbits);

    rrw_ram #(
        .WIDTH (CHW),
        .DEPTH (CHANNELS)
    ) u_chan_ram (
        .clk   (clk),
        .we    (chan_we),
        .waddr (chan_waddr),
        .wdata (chan_wdata),
        .re    (chan_re),
        .raddr (chan_raddr),
        .rdata (chan_rdata)
    );

    rrw_seqmod #(
        .WINDOW (WINDOW)
    ) u_seqmod (
        .clk (clk),
        .en  (mod_en),
        .x   (req.sequence_req),
        .idx (mod_idx)
    );

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic logic [SAW-1:0] slot_addr(input logic [CH_W-1:0] ch,
                                                 input logic [IW-1:0] idx);
        logic [PW-1:0] base;
        base      = PW'(ch[CW-1:0]) * PW'(WINDOW);
        slot_addr = SAW'(base) + SAW'(idx);
    endfunction

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
        idx_inc = (idx == IW'(WINDOW - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic rsp_t make_rsp(input kind_t kind, input logic [CH_W-1:0] ch,
                                      input logic [SEQ_W-1:0] first,
                                      input logic [SEQ_W-1:0] last_seq,
                                      input logic [SUB_W-1:0] sub,
                                      input logic [PAY_W-1:0] pay);
        rsp_t r;
        r.kind           = kind;
        r.out_channel    = ch;
        r.first_sequence = first;
        r.last_sequence  = last_seq;
        r.out_subtype    = sub;
        r.out_payload    = pay;
        r.last           = 1'b0;
        make_rsp         = r;
    endfunction

    logic ch_ok_in, ch_ok;
    logic out_free, hold;
    logic emit_req, fin_push;
    rsp_t emit_rsp;

    assign ch_ok_in = (req.channel < CH_W'(CHANNELS));
    assign ch_ok    = (ch_reg < CH_W'(CHANNELS));
    assign out_free = !rsp_valid_reg || rsp_ready;
    // a new result needs the staged one moved out first
    assign hold     = pend_valid_reg && !out_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        op_next     = op_reg;
        ch_next     = ch_reg;
        seq_next    = seq_reg;
        sub_next    = sub_reg;
        pay_next    = pay_reg;
        exp_next    = exp_reg;
        rd_next     = rd_reg;
        rdidx_next  = rdidx_reg;
        gap_next    = gap_reg;
        cidx_next   = cidx_reg;
        guard_next  = guard_reg;

        emit_req    = 1'b0;
        emit_rsp    = make_rsp(KIND_NONE, ch_reg, '0, '0, '0, '0);
        fin_push    = 1'b0;

        slot_we     = 1'b0;
        slot_waddr  = clr_reg;
        slot_wdata  = '0;
        slot_re     = 1'b0;
        slot_raddr  = slot_addr(ch_reg, cidx_reg);
        chan_we     = 1'b0;
        chan_waddr  = CW'(clr_reg);
        chan_wdata  = '0;
        chan_re     = 1'b0;
        chan_raddr  = req.channel[CW-1:0];
        mod_en      = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                slot_we  = 1'b1;
                chan_we  = (clr_reg < SAW'(CHANNELS));
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SAW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next  = req.operation;
                    ch_next  = req.channel;
                    seq_next = req.sequence_req;
                    sub_next = req.subtype;
                    pay_next = req.payload;
                    chan_re  = 1'b1;
                    mod_en   = 1'b1;
                    state_next = ch_ok_in ? ST_LOAD : ST_REJ;
                end
            end
            ST_LOAD:
            begin
                exp_next   = chan_rdata[SEQ_W-1:0];
                rd_next    = chan_rdata[2*SEQ_W-1:SEQ_W];
                rdidx_next = chan_rdata[2*SEQ_W+IW-1:2*SEQ_W];
                gap_next   = chan_rdata[CHW-1];
                state_next = (op_reg == OP_ACCEPT) ? ST_SLOT : ST_POP;
            end
            ST_SLOT:
            begin
                if (!hold)
                begin
                    slot_we            = 1'b1;
                    slot_waddr         = slot_addr(ch_reg, mod_idx);
                    slot_wdata.present = 1'b1;
                    slot_wdata.seq     = seq_reg;
                    slot_wdata.sub     = sub_reg;
                    slot_wdata.pay     = pay_reg;
                    if (exp_reg == seq_reg)
                    begin
                        emit_req   = 1'b1;
                        emit_rsp   = make_rsp(KIND_ADVANCED, ch_reg, seq_reg, '0,
                                              sub_reg, pay_reg);
                        exp_next   = seq_reg + 1'b1;
                        guard_next = GW'(1);
                        cidx_next  = idx_inc(mod_idx);
                        slot_re    = 1'b1;
                        slot_raddr = slot_addr(ch_reg, idx_inc(mod_idx));
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_GAPCHK;
                    end
                end
            end
            ST_WALK:
            begin
                if (!hold)
                begin
                    if (!slot_rd.present)
                    begin
                        state_next = ST_GAPCHK;
                    end
                    else
                    begin
                        // walking into a present slot drops the gap flag
                        gap_next = 1'b0;
                        if (guard_reg != GW'(WINDOW) && exp_reg == slot_rd.seq)
                        begin
                            emit_req   = 1'b1;
                            emit_rsp   = make_rsp(KIND_ADVANCED, ch_reg, slot_rd.seq, '0,
                                                  slot_rd.sub, slot_rd.pay);
                            exp_next   = slot_rd.seq + 1'b1;
                            guard_next = guard_reg + 1'b1;
                            cidx_next  = idx_inc(cidx_reg);
                            slot_re    = 1'b1;
                            slot_raddr = slot_addr(ch_reg, idx_inc(cidx_reg));
                        end
                        else
                        begin
                            state_next = ST_GAPCHK;
                        end
                    end
                end
            end
            ST_GAPCHK:
            begin
                if (!hold)
                begin
                    if (exp_reg < seq_reg && !gap_reg)
                    begin
                        emit_req = 1'b1;
                        emit_rsp = make_rsp(KIND_GAP, ch_reg, exp_reg, seq_reg - 1'b1,
                                            '0, '0);
                        gap_next = 1'b1;
                    end
                    state_next = ST_FIN;
                end
            end
            ST_POP:
            begin
                if (!hold)
                begin
                    if (rd_reg >= exp_reg)
                    begin
                        emit_req   = 1'b1;
                        emit_rsp   = make_rsp(KIND_NONE, ch_reg, '0, '0, '0, '0);
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        slot_re    = 1'b1;
                        slot_raddr = slot_addr(ch_reg, rdidx_reg);
                        state_next = ST_POPRD;
                    end
                end
            end
            ST_POPRD:
            begin
                if (!hold)
                begin
                    emit_req = 1'b1;
                    if (!slot_rd.present)
                    begin
                        // empty slot: ask for a refill range
                        emit_rsp = make_rsp(KIND_GAP, ch_reg, rd_reg,
                                            rd_reg + SEQ_W'(span_reg), '0, '0);
                    end
                    else
                    begin
                        emit_rsp           = make_rsp(KIND_POPPED, ch_reg, slot_rd.seq, '0,
                                                      slot_rd.sub, slot_rd.pay);
                        slot_we            = 1'b1;
                        slot_waddr         = slot_addr(ch_reg, rdidx_reg);
                        slot_wdata         = slot_rd;
                        slot_wdata.present = 1'b0;
                        rd_next            = rd_reg + 1'b1;
                        rdidx_next         = idx_inc(rdidx_reg);
                    end
                    state_next = ST_FIN;
                end
            end
            ST_REJ:
            begin
                if (!hold)
                begin
                    emit_req   = 1'b1;
                    emit_rsp   = make_rsp(KIND_REJECT, ch_reg, '0, '0, '0, '0);
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!hold)
                begin
                    fin_push   = pend_valid_reg;
                    chan_we    = ch_ok;
                    chan_waddr = ch_reg[CW-1:0];
                    chan_wdata = {gap_reg, rdidx_reg, rd_reg, exp_reg};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // result staging: a result is held until the next one (or the end of
    // the request) tells whether it is the last
    // ------------------------------------------------------------------
    always_comb
    begin
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;

        if (emit_req)
        begin
            if (pend_valid_reg)
            begin
                rsp_next       = pend_reg;
                rsp_valid_next = 1'b1;
            end
            pend_next       = emit_rsp;
            pend_valid_next = 1'b1;
        end

        if (fin_push)
        begin
            rsp_next        = pend_reg;
            rsp_next.last   = 1'b1;
            rsp_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            span_reg       <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg_we)
            begin
                span_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        ch_reg    <= ch_next;
        seq_reg   <= seq_next;
        sub_reg   <= sub_next;
        pay_reg   <= pay_next;
        exp_reg   <= exp_next;
        rd_reg    <= rd_next;
        rdidx_reg <= rdidx_next;
        gap_reg   <= gap_next;
        cidx_reg  <= cidx_next;
        guard_reg <= guard_next;
        pend_reg  <= pend_next;
        rsp_reg   <= rsp_next;
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------

    // nothing left staged once a request has finished
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("staged result left over in idle");

    // the walk never goes past one full window
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (guard_reg <= GW'(WINDOW)))
        else $error("advance walk exceeded window");

    // reciprocal modulo lands inside the window
    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SLOT) |-> (mod_idx < IW'(WINDOW) || WINDOW == (1 << IW)))
        else $error("slot index out of window");

    // a finished request leaves its final result in the output register
    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && fin_push) |=> (rsp_valid_reg && rsp_reg.last))
        else $error("final result not flagged last");

endmodule

### tb/tb_reliable_reorder_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reliable_reorder_window
// Self-checking bench for the per-channel reorder window. Request beats are
// driven with random gaps, results are drained with random stalls, and each
// result beat is matched field by field against a scoreboard fed by an
// in-bench model of the window state (expected point, read point, gap flag,
// slot store and refill span).
// ----------------------------------------------------------------------------
module tb_reliable_reorder_window;
    import rrw_pkg::*;

    localparam int CHANNELS      = CHANNELS_DEF;
    localparam int WINDOW        = WINDOW_DEF;
    localparam int DEPTH         = CHANNELS * WINDOW;
    localparam int SETTLE_CYCLES = 64;   // covers the longest accept, a walk over a full window
    localparam int RANDOM_ITEMS  = 330;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             req_valid = 1'b0;
    logic             req_ready;
    req_t             req       = '0;
    logic             rsp_valid;
    logic             rsp_ready = 1'b0;
    rsp_t             rsp;
    logic             cfg_we    = 1'b0;
    logic [SPAN_W-1:0] cfg_wdata = '0;

    // model of the window, all zero after reset
    bit [SEQ_W-1:0]  next_adv  [CHANNELS];
    bit [SEQ_W-1:0]  next_read [CHANNELS];
    bit              gap_open  [CHANNELS];
    bit              slot_full [DEPTH];
    bit [SEQ_W-1:0]  slot_seq  [DEPTH];
    bit [SUB_W-1:0]  slot_sub  [DEPTH];
    bit [PAY_W-1:0]  slot_pay  [DEPTH];
    bit [SPAN_W-1:0] refill_span;

    rsp_t due_results[$];
    int   errors = 0;
    bit   calm   = 1'b0;    // no idling on either side while set

    always #5 clk = ~clk;

    reliable_reorder_window #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // window model
    // ------------------------------------------------------------------------
    function automatic int unsigned slot_idx(input int unsigned ch,
                                             input logic [SEQ_W-1:0] seq);
        return ch * WINDOW + int'(seq % WINDOW);
    endfunction

    function automatic rsp_t result_beat(input kind_t k, input logic [CH_W-1:0] ch,
                                         input logic [SEQ_W-1:0] first,
                                         input logic [SEQ_W-1:0] lastseq,
                                         input logic [SUB_W-1:0] sub,
                                         input logic [PAY_W-1:0] pay);
        rsp_t r;
        r.kind           = k;
        r.out_channel    = ch;
        r.first_sequence = first;
        r.last_sequence  = lastseq;
        r.out_subtype    = sub;
        r.out_payload    = pay;
        r.last           = 1'b0;
        return r;
    endfunction

    function automatic req_t pack_request(input op_t op, input logic [CH_W-1:0] ch,
                                          input logic [SEQ_W-1:0] seq,
                                          input logic [SUB_W-1:0] sub,
                                          input logic [PAY_W-1:0] pay);
        req_t r;
        r.operation    = op;
        r.channel      = ch;
        r.sequence_req = seq;
        r.subtype      = sub;
        r.payload      = pay;
        return r;
    endfunction

    // Applies one accepted request to the model and queues its results.
    function automatic void window_predict(input req_t r);
        rsp_t           outs[$];
        int unsigned    ch, s, cs, ns, guard;
        logic [SEQ_W-1:0] cur, nx, rs;
        ch = r.channel;
        if (ch >= CHANNELS) begin
            outs.push_back(result_beat(KIND_REJECT, r.channel, '0, '0, '0, '0));
        end else if (r.operation == OP_ACCEPT) begin
            s            = slot_idx(ch, r.sequence_req);
            slot_full[s] = 1'b1;
            slot_seq[s]  = r.sequence_req;
            slot_sub[s]  = r.subtype;
            slot_pay[s]  = r.payload;
            cur          = r.sequence_req;
            guard        = 0;
            // advance while the chain of stored slots stays in order
            while (next_adv[ch] == cur && guard < WINDOW) begin
                cs           = slot_idx(ch, cur);
                nx           = cur + 1;
                ns           = slot_idx(ch, nx);
                guard        = guard + 1;
                next_adv[ch] = nx;
                outs.push_back(result_beat(KIND_ADVANCED, r.channel, slot_seq[cs], '0,
                                           slot_sub[cs], slot_pay[cs]));
                if (!slot_full[ns])
                    break;
                cur          = slot_seq[ns];
                gap_open[ch] = 1'b0;
            end
            if (next_adv[ch] < r.sequence_req && !gap_open[ch]) begin
                gap_open[ch] = 1'b1;
                outs.push_back(result_beat(KIND_GAP, r.channel, next_adv[ch],
                                           r.sequence_req - 1, '0, '0));
            end
        end else begin
            rs = next_read[ch];
            if (rs >= next_adv[ch]) begin
                outs.push_back(result_beat(KIND_NONE, r.channel, '0, '0, '0, '0));
            end else begin
                s = slot_idx(ch, rs);
                if (!slot_full[s]) begin
                    // slot already handed out: ask for a refill range
                    outs.push_back(result_beat(KIND_GAP, r.channel, rs,
                                               rs + refill_span, '0, '0));
                end else begin
                    outs.push_back(result_beat(KIND_POPPED, r.channel, slot_seq[s], '0,
                                               slot_sub[s], slot_pay[s]));
                    slot_full[s]  = 1'b0;
                    next_read[ch] = rs + 1;
                end
            end
        end
        if (outs.size() > 0)
            outs[outs.size()-1].last = 1'b1;
        foreach (outs[i])
            due_results.push_back(outs[i]);
    endfunction

    // ------------------------------------------------------------------------
    // drive / drain helpers
    // ------------------------------------------------------------------------
    task automatic push_beat(input req_t item);
        int hold;
        if (!calm && $urandom_range(0, 99) < 13) begin
            hold = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (hold) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_ready !== 1'b1) @(posedge clk);
        window_predict(item);
    endtask

    // hold off until every queued result is back, then let a zero-result
    // accept finish its walk
    task automatic quiesce();
        req_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_span(input logic [SPAN_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        refill_span = value;
    endtask

    // receiver side: random stalls unless in a calm stretch
    always @(posedge clk)
        rsp_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 13);

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk) begin : result_check
        rsp_t want;
        if (rst_n && rsp_valid === 1'b1 && rsp_ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %h", $time, rsp);
                errors++;
            end else begin
                want = due_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(rsp.kind));
                check_field("out_channel", 32'(want.out_channel), 32'(rsp.out_channel));
                check_field("first_sequence", want.first_sequence, rsp.first_sequence);
                check_field("last_sequence", want.last_sequence, rsp.last_sequence);
                check_field("out_subtype", 32'(want.out_subtype), 32'(rsp.out_subtype));
                check_field("out_payload", want.out_payload, rsp.out_payload);
                check_field("last", 32'(want.last), 32'(rsp.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_reject_channels();
        push_beat(pack_request(OP_ACCEPT, 8'd8, 32'h0, 8'hA5, 32'h1234_5678));
        push_beat(pack_request(OP_ACCEPT, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
        push_beat(pack_request(OP_POP, 8'hFF, 32'h0, 8'h0, 32'h0));
    endtask

    task automatic test_in_order();
        push_beat(pack_request(OP_ACCEPT, 8'd0, 32'd0, 8'hFF, 32'hFFFF_FFFF));
        push_beat(pack_request(OP_ACCEPT, 8'd0, 32'd1, 8'h00, 32'h0000_0000));
        push_beat(pack_request(OP_POP, 8'd0, 32'd0, 8'h0, 32'h0));
        push_beat(pack_request(OP_POP, 8'd0, 32'd0, 8'h0, 32'h0));
        push_beat(pack_request(OP_POP, 8'd0, 32'd0, 8'h0, 32'h0));   // nothing ready
    endtask

    // out-of-order arrivals: gap raised, silent stores, chained fill, then a new gap
    task automatic test_gap_fill();
        int seqs[7] = '{3, 5, 1, 0, 2, 4, 7};
        foreach (seqs[i])
            push_beat(pack_request(OP_ACCEPT, 8'd1, 32'(seqs[i]),
                                   8'($urandom_range(0, 255)), $urandom()));
    endtask

    task automatic test_sequence_extreme();
        push_beat(pack_request(OP_ACCEPT, 8'd7, 32'hFFFF_FFFF, 8'h5A, $urandom()));
        push_beat(pack_request(OP_POP, 8'd7, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF));
        push_beat(pack_request(OP_ACCEPT, 8'd7, 32'd0, 8'h00, $urandom()));
    endtask

    // Fill past one window so slot 0 is overwritten, pop it all back, then the
    // read point lands on the already emptied slot: refill request.
    task automatic test_refill();
        int i;
        for (i = 0; i <= WINDOW; i++)
            push_beat(pack_request(OP_ACCEPT, 8'd3, 32'(i), 8'($urandom_range(0, 255)),
                                   $urandom()));
        for (i = 0; i <= WINDOW; i++)
            push_beat(pack_request(OP_POP, 8'd3, $urandom(), 8'h0, 32'h0));
        quiesce();
        set_span(8'd0);
        push_beat(pack_request(OP_POP, 8'd3, 32'h0, 8'h0, 32'h0));
        quiesce();
        set_span(8'd77);
        push_beat(pack_request(OP_POP, 8'd3, 32'h0, 8'h0, 32'h0));
    endtask

    // a full window stored in reverse, released by the head: longest walk
    task automatic test_long_walk();
        int i;
        for (i = WINDOW - 1; i >= 0; i--)
            push_beat(pack_request(OP_ACCEPT, 8'd4, 32'(i), 8'($urandom_range(0, 255)),
                                   $urandom()));
    endtask

    task automatic test_random();
        req_t         item;
        int           i, pick;
        int unsigned  ch;
        logic [31:0]  seq;
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == 150) begin
                quiesce();
                set_span(8'($urandom_range(0, 255)));
            end
            calm = (i >= 200 && i < 280);
            pick = $urandom_range(0, 99);
            ch   = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1)
                                                : $urandom_range(0, CHANNELS - 1);
            // mostly arrivals near the in-order point, some far ahead or stale
            if (pick < 55)
                seq = next_adv[ch] + $urandom_range(0, 8);
            else if (pick < 62)
                seq = next_adv[ch] + $urandom_range(9, 40);
            else if (pick < 65)
                seq = next_adv[ch] - $urandom_range(1, 40);
            else
                seq = $urandom();
            if (pick < 68)
                item = pack_request(OP_ACCEPT, 8'(ch), seq, 8'($urandom_range(0, 255)),
                                    $urandom());
            else if (pick < 90)
                item = pack_request(OP_POP, 8'(ch), seq, 8'($urandom_range(0, 255)),
                                    $urandom());
            else
                item = pack_request(op_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                    $urandom(), 8'($urandom_range(0, 255)), $urandom());
            push_beat(item);
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (req_ready !== 1'b1) @(posedge clk);   // clearing pass
        set_span(8'hFF);
        test_reject_channels();
        test_in_order();
        test_gap_fill();
        test_sequence_extreme();
        quiesce();
        test_refill();
        quiesce();
        test_long_walk();
        quiesce();
        set_span(8'($urandom_range(1, 254)));
        test_random();
        quiesce();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
